// File: sv/c8x_pkg.sv
// Shared types, codes and decode helpers for the CHIP-8 execute unit.
// No dependencies.
`timescale 1ns / 1ps
package c8x_pkg;

  localparam int MemoryBytesDefault = 4096;
  localparam int StackDepthDefault  = 16;
  localparam logic [11:0] ProgramStartReset = 12'd512;

  localparam logic [1:0] MODE_INSTR = 2'd0;
  localparam logic [1:0] MODE_KEY   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_NOT_HANDLED = 3'd2;
  localparam logic [2:0] ST_END_MEM     = 3'd3;
  localparam logic [2:0] ST_WAIT        = 3'd4;

  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_LDDT = 8'h07;
  localparam logic [7:0] KK_WAIT = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] opcode;
    logic [3:0]  key_id;
    logic        key_pressed;
    logic [7:0]  random_byte;
  } in_word_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [2:0]  status;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [7:0]  reg_value;
    logic [7:0]  flag_value;
    logic [15:0] index_value;
    logic        waiting_key;
    logic        sound_active;
  } out_word_t;

  // Word after classification by the front end.
  typedef struct packed {
    in_word_t   w;
    logic       not_handled;
    logic       invalid_code;
  } cls_word_t;

  function automatic logic [1:0] classify(input logic [15:0] op);
    logic nh;
    logic inv;
    begin
      nh = 1'b0;
      inv = 1'b0;
      unique case (op[15:12])
        4'h0: nh = (op != OP_RET);
        4'h5, 4'h9: inv = (op[3:0] != 4'h0);
        4'h8: inv = !(op[3:0] <= 4'h7 || op[3:0] == 4'hE);
        4'hD: nh = 1'b1;
        4'hE: inv = !(op[7:0] == KK_SKP || op[7:0] == KK_SKNP);
        4'hF: begin
          nh = (op[7:0] == 8'h29 || op[7:0] == 8'h30 || op[7:0] == 8'h33 ||
                op[7:0] == 8'h55 || op[7:0] == 8'h65 || op[7:0] == 8'h75 ||
                op[7:0] == 8'h85);
          inv = !(nh || op[7:0] == KK_LDDT || op[7:0] == KK_WAIT ||
                  op[7:0] == KK_SETDT || op[7:0] == KK_SETST || op[7:0] == KK_ADDI);
        end
        default: begin
          nh = 1'b0;
          inv = 1'b0;
        end
      endcase
      return {nh, inv};
    end
  endfunction

endpackage

// File: sv/c8x_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module c8x_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/c8x_front.sv
// Front end: accepts words and tags decode class into a two-entry queue.
// Depends on c8x_pkg.
`timescale 1ns / 1ps
module c8x_front import c8x_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_word_t  in_word,
  output logic      full,
  output logic      q_valid,
  output cls_word_t q_word,
  input  logic      q_take
);
  cls_word_t   slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic [1:0]  cls;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_word  = slot[rd_ptr];
  assign cls     = classify(in_word.opcode);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= '{w: in_word, not_handled: cls[1], invalid_code: cls[0]};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, q_take};
    end
  end
endmodule

// File: sv/c8x_back.sv
// Back end: executes one classified word per cycle into an output queue, unless stalled.
// Depends on c8x_pkg and c8x_ram.
`timescale 1ns / 1ps
module c8x_back import c8x_pkg::*; #(
  parameter int MemoryBytes = MemoryBytesDefault,
  parameter int StackDepth  = StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_pc,
  input  logic        q_valid,
  input  cls_word_t   q_word,
  output logic        q_take,
  output logic        empty,
  output out_word_t   out_word,
  input  logic        pop
);
  localparam int SpW = $clog2(StackDepth);
  localparam int DepW = $clog2(StackDepth + 1);
  localparam logic [11:0] PcLimit = 12'(MemoryBytes - 2);

  logic [7:0]  vreg [16];
  logic [15:0] index_reg;
  logic [11:0] pc_reg;
  logic [DepW-1:0] stack_depth;
  logic [7:0]  delay_count;
  logic [7:0]  sound_count;
  logic [15:0] key_states;
  logic        waiting_flag;
  logic [3:0]  wait_target;

  // Return stack: the top entry is read ahead from the RAM. After each
  // push/pop the top address changes, so the read is issued as it fires
  // with the new depth, and a return stalls while the read data is stale.
  logic          top_fresh;
  logic [11:0]   stk_rdata;
  logic          stk_we;
  logic [SpW-1:0] stk_waddr;
  logic [SpW-1:0] stk_raddr;
  logic [DepW-1:0] depth_next;

  // Output queue of two entries.
  out_word_t   oslot [2];
  logic        o_rd, o_wr;
  logic [1:0]  o_cnt;

  logic [3:0] x, y, hi, lo;
  logic [7:0] kk, vx, vy;
  logic [11:0] nnn;
  logic [8:0] sum9;
  logic       is_ret;
  logic       stall;
  logic       fire;

  // Next-state values.
  logic [11:0] pc_n;
  logic [2:0]  st;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [7:0]  wr_val;
  logic        flag_en;
  logic [7:0]  flag_val;
  logic [15:0] index_n;
  logic [7:0]  delay_n, sound_n;
  logic [15:0] keys_n;
  logic        wait_n;
  logic [3:0]  target_n;
  logic        push_s, pop_s;
  logic [11:0] adv;

  assign hi  = q_word.w.opcode[15:12];
  assign x   = q_word.w.opcode[11:8];
  assign y   = q_word.w.opcode[7:4];
  assign lo  = q_word.w.opcode[3:0];
  assign kk  = q_word.w.opcode[7:0];
  assign nnn = q_word.w.opcode[11:0];
  assign vx  = vreg[x];
  assign vy  = vreg[y];
  assign sum9 = {1'b0, vx} + {1'b0, vy};

  assign is_ret = q_word.w.mode == MODE_INSTR && q_word.w.opcode == OP_RET &&
                  pc_reg <= PcLimit && !waiting_flag && stack_depth != '0;
  assign stall  = is_ret && !top_fresh;
  assign fire   = q_valid && !stall && (o_cnt != 2'd2);
  assign q_take = fire;

  assign stk_we    = fire && push_s;
  assign stk_waddr = stack_depth[SpW-1:0];
  assign depth_next = fire ? (push_s ? stack_depth + 1'b1 :
                              pop_s ? stack_depth - 1'b1 : stack_depth) : stack_depth;
  assign stk_raddr = SpW'(depth_next - 1'b1);

  c8x_ram #(.Width(12), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(pc_reg),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_comb begin
    pc_n = pc_reg; st = ST_DONE; wr_en = 1'b0; wr_idx = 4'd0; wr_val = 8'd0;
    flag_en = 1'b0; flag_val = 8'd0; index_n = index_reg;
    delay_n = delay_count; sound_n = sound_count; keys_n = key_states;
    wait_n = waiting_flag; target_n = wait_target; push_s = 1'b0; pop_s = 1'b0;
    adv = 12'd2;
    unique case (q_word.w.mode)
      MODE_INSTR: begin
        if (pc_reg > PcLimit) begin
          st = ST_END_MEM;
        end else if (waiting_flag) begin
          st = ST_WAIT;
        end else if (q_word.not_handled) begin
          st = ST_NOT_HANDLED;
          pc_n = pc_reg + adv;
        end else if (q_word.invalid_code) begin
          st = ST_INVALID;
          pc_n = pc_reg + adv;
        end else begin
          unique case (hi)
            4'h0: begin
              if (stack_depth == '0) begin st = ST_INVALID; pc_n = pc_reg + adv; end
              else begin pop_s = 1'b1; pc_n = stk_rdata + adv; end
            end
            4'h1: pc_n = nnn;
            4'h2: begin
              if (stack_depth >= DepW'(StackDepth)) begin
                st = ST_INVALID; pc_n = pc_reg + adv;
              end else begin
                push_s = 1'b1; pc_n = nnn;
              end
            end
            4'h3: pc_n = pc_reg + ((vx == kk) ? 12'd4 : adv);
            4'h4: pc_n = pc_reg + ((vx != kk) ? 12'd4 : adv);
            4'h5: pc_n = pc_reg + ((vx == vy) ? 12'd4 : adv);
            4'h9: pc_n = pc_reg + ((vx != vy) ? 12'd4 : adv);
            4'h6: begin wr_en = 1'b1; wr_val = kk; pc_n = pc_reg + adv; end
            4'h7: begin wr_en = 1'b1; wr_val = vx + kk; pc_n = pc_reg + adv; end
            4'h8: begin
              wr_en = 1'b1; pc_n = pc_reg + adv;
              unique case (lo)
                4'h0: wr_val = vy;
                4'h1: wr_val = vx | vy;
                4'h2: wr_val = vx & vy;
                4'h3: wr_val = vx ^ vy;
                4'h4: begin wr_val = sum9[7:0]; flag_en = 1'b1;
                  flag_val = {7'd0, sum9[8]}; end
                4'h5: begin wr_val = vx - vy; flag_en = 1'b1;
                  flag_val = {7'd0, vx >= vy}; end
                4'h6: begin wr_val = {1'b0, vx[7:1]}; flag_en = 1'b1;
                  flag_val = {7'd0, vx[0]}; end
                4'h7: begin wr_val = vy - vx; flag_en = 1'b1;
                  flag_val = {7'd0, vy >= vx}; end
                default: begin wr_val = {vx[6:0], 1'b0}; flag_en = 1'b1;
                  flag_val = {7'd0, vx[7]}; end
              endcase
            end
            4'hA: begin index_n = {4'd0, nnn}; pc_n = pc_reg + adv; end
            4'hB: pc_n = nnn + {4'd0, vreg[0]};
            4'hC: begin wr_en = 1'b1; wr_val = kk & q_word.w.random_byte;
              pc_n = pc_reg + adv; end
            4'hE: begin
              if ((kk == KK_SKP) == key_states[vx[3:0]]) pc_n = pc_reg + 12'd4;
              else pc_n = pc_reg + adv;
            end
            default: begin
              pc_n = pc_reg + adv;
              priority case (kk)
                KK_LDDT: begin wr_en = 1'b1; wr_val = delay_count; end
                KK_WAIT: begin wait_n = 1'b1; target_n = x; end
                KK_SETDT: delay_n = vx;
                KK_SETST: sound_n = vx;
                default: index_n = index_reg + {8'd0, vx};
              endcase
            end
          endcase
          if (wr_en) wr_idx = x;
        end
      end
      MODE_KEY: begin
        keys_n[q_word.w.key_id] = q_word.w.key_pressed;
        if (waiting_flag && q_word.w.key_pressed) begin
          wr_en = 1'b1; wr_idx = wait_target; wr_val = {4'd0, q_word.w.key_id};
          wait_n = 1'b0;
        end
      end
      MODE_TICK: begin
        if (delay_count != 8'd0) delay_n = delay_count - 8'd1;
        if (sound_count != 8'd0) sound_n = sound_count - 8'd1;
      end
      default: st = ST_INVALID;
    endcase
  end

  assign empty    = (o_cnt == 2'd0);
  assign out_word = oslot[o_rd];

  always_ff @(posedge clk) begin
    if (fire) begin
      // When the flag op targets VF itself, the flag is the value kept.
      if (wr_en && !(flag_en && wr_idx == 4'hF)) vreg[wr_idx] <= wr_val;
      if (flag_en) vreg[15] <= flag_val;
      oslot[o_wr] <= '{
        next_pc: pc_n, status: st, reg_written: wr_en, reg_index: wr_idx,
        reg_value: wr_val,
        flag_value: flag_en ? flag_val : ((wr_en && wr_idx == 4'hF) ? wr_val : vreg[15]),
        index_value: index_n, waiting_key: wait_n, sound_active: sound_n != 8'd0};
    end
    if (rst) begin
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
      index_reg <= 16'd0; pc_reg <= ProgramStartReset; stack_depth <= '0;
      delay_count <= 8'd0; sound_count <= 8'd0; key_states <= 16'd0;
      waiting_flag <= 1'b0; wait_target <= 4'd0; top_fresh <= 1'b0;
      o_rd <= 1'b0; o_wr <= 1'b0; o_cnt <= 2'd0;
    end else begin
      top_fresh <= 1'b1;
      if (cfg_we) pc_reg <= cfg_pc;
      if (fire) begin
        if (!cfg_we) pc_reg <= pc_n;
        index_reg <= index_n; delay_count <= delay_n; sound_count <= sound_n;
        key_states <= keys_n; waiting_flag <= wait_n; wait_target <= target_n;
        stack_depth <= depth_next;
        if (push_s || pop_s) top_fresh <= 1'b0;
        o_wr <= ~o_wr;
      end
      if (!empty && pop) o_rd <= ~o_rd;
      o_cnt <= o_cnt + {1'b0, fire} - {1'b0, !empty && pop};
    end
  end
endmodule

// File: sv/chip8_instruction_execute.sv
// CHIP-8 execute unit. A pushed word is registered in the front queue, then
// executed into the result queue and shown while empty is low. Throughput:
// one word per cycle while the result queue has room; a return (00EE) right
// after a call or a return stalls for the registered read of the return-stack RAM.
// Reset (rst, synchronous): registers, I, timers, keys and stack depth clear,
// the program counter loads 512 and both queues empty. Depends on c8x_pkg, c8x_front and c8x_back.
`timescale 1ns / 1ps
module chip8_instruction_execute import c8x_pkg::*; #(
  parameter int MemoryBytes = MemoryBytesDefault,
  parameter int StackDepth  = StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  // Input queue side.
  input  logic        push,
  input  in_word_t    in_word,
  output logic        full,
  // Result queue side.
  output logic        empty,
  output out_word_t   out_word,
  input  logic        pop,
  // Configuration port; one register, program_start, at address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic        q_valid;
  cls_word_t   q_word;
  logic        q_take;
  logic [11:0] program_start;
  logic        cfg_we;

  // The register is written at the access phase. A write also loads the
  // program counter directly; the user must write only while the block is
  // idle, which the block itself does not enforce.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr == 2'd0;
  assign prdata = (paddr == 2'd0) ? {20'd0, program_start} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_start <= ProgramStartReset;
    end else if (cfg_we) begin
      program_start <= pwdata[11:0];
    end
  end

  // The front end classifies each word into a two-entry queue so the
  // back end can stall on a stack read or a full result queue.
  c8x_front u_front (
    .clk(clk), .rst(rst), .push(push), .in_word(in_word), .full(full),
    .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
  );

  c8x_back #(.MemoryBytes(MemoryBytes), .StackDepth(StackDepth)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_pc(pwdata[11:0]),
    .q_valid(q_valid), .q_word(q_word), .q_take(q_take),
    .empty(empty), .out_word(out_word), .pop(pop)
  );

  // The back end never takes a word that the front queue does not hold.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("back end took from an empty queue");

  // A full front queue stays full until the back end takes a word, so no
  // word that it holds is lost.
  a_full_held: assert property (@(posedge clk) disable iff (rst)
    (full && !q_take) |=> full) else $error("front queue lost a word");

  // Results only appear after a word was executed.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    ($past(empty) && !empty) |-> $past(q_take)) else $error("result without word");
endmodule

// File: dv/tb.sv
// Self-checking testbench for chip8_instruction_execute: a cycle-free predictor
// drives an expected-word queue that is checked against each popped result word.
// Depends on c8x_pkg and the chip8_instruction_execute RTL.
`timescale 1ns / 1ps
module tb;
  import c8x_pkg::*;

  // Major opcode nibbles.
  localparam logic [3:0] OPC_SYS = 4'h0, OPC_JP = 4'h1, OPC_CALL = 4'h2, OPC_SE = 4'h3;
  localparam logic [3:0] OPC_SNE = 4'h4, OPC_SEV = 4'h5, OPC_LD = 4'h6, OPC_ADD = 4'h7;
  localparam logic [3:0] OPC_ALU = 4'h8, OPC_SNEV = 4'h9, OPC_LDI = 4'hA, OPC_JPV = 4'hB;
  localparam logic [3:0] OPC_RND = 4'hC, OPC_DRW = 4'hD, OPC_KEY = 4'hE, OPC_MISC = 4'hF;
  // ALU sub-operations.
  localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam logic [1:0] ADDR_PROGRAM_START = 2'd0;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [11:0] PC_LAST = 12'd4095;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  in_word_t    in_word = '0;
  logic        full;
  logic        empty;
  out_word_t   out_word;
  logic        pop = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chip8_instruction_execute dut (
    .clk, .rst, .push, .in_word, .full, .empty, .out_word, .pop,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Shadow copy of the architectural state.
  logic [7:0]  vreg [16];
  logic [11:0] call_stack [16];
  logic [15:0] idx_reg;
  logic [11:0] pc_q;
  int          depth;
  logic [7:0]  delay_q, sound_q;
  logic [15:0] keys_q;
  logic        waiting_q;
  logic [3:0]  target_q;

  out_word_t expected_words [$];
  int        errors = 0;
  int        cycles = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  function automatic out_word_t execute_word(in_word_t w);
    out_word_t r;
    logic [3:0] hi, x, y, lo;
    logic [7:0] kk, vx, vy;
    logic [8:0] sum;
    logic [11:0] nxt;
    logic [3:0] adv;
    r = '0;
    r.status = ST_DONE;
    hi = w.opcode[15:12]; x = w.opcode[11:8]; y = w.opcode[7:4]; lo = w.opcode[3:0];
    kk = w.opcode[7:0]; vx = vreg[x]; vy = vreg[y];
    case (w.mode)
      MODE_INSTR: begin
        if (pc_q == PC_LAST) r.status = ST_END_MEM;
        else if (waiting_q) r.status = ST_WAIT;
        else begin
          nxt = pc_q;
          adv = 4'd2;
          case (hi)
            OPC_SYS: begin
              if (w.opcode != OP_RET) r.status = ST_NOT_HANDLED;
              else if (depth == 0) r.status = ST_INVALID;
              else begin
                depth--;
                nxt = call_stack[4'(depth)];
              end
            end
            OPC_JP: begin nxt = w.opcode[11:0]; adv = 4'd0; end
            OPC_CALL: begin
              if (depth >= 16) r.status = ST_INVALID;
              else begin
                call_stack[4'(depth)] = pc_q;
                depth++;
                nxt = w.opcode[11:0];
                adv = 4'd0;
              end
            end
            OPC_SE: if (vx == kk) adv = 4'd4;
            OPC_SNE: if (vx != kk) adv = 4'd4;
            OPC_SEV, OPC_SNEV: begin
              if (lo != 4'd0) r.status = ST_INVALID;
              else if ((vx == vy) == (hi == OPC_SEV)) adv = 4'd4;
            end
            OPC_LD: begin r.reg_written = 1'b1; r.reg_value = kk; end
            OPC_ADD: begin r.reg_written = 1'b1; r.reg_value = vx + kk; end
            OPC_ALU: begin
              r.reg_written = 1'b1;
              case (lo)
                ALU_MOV: r.reg_value = vy;
                ALU_OR:  r.reg_value = vx | vy;
                ALU_AND: r.reg_value = vx & vy;
                ALU_XOR: r.reg_value = vx ^ vy;
                ALU_ADD: begin sum = {1'b0, vx} + {1'b0, vy}; r.reg_value = sum[7:0]; end
                ALU_SUB: r.reg_value = vx - vy;
                ALU_SHR: r.reg_value = vx >> 1;
                ALU_SUBN: r.reg_value = vy - vx;
                ALU_SHL: r.reg_value = vx << 1;
                default: begin r.reg_written = 1'b0; r.status = ST_INVALID; end
              endcase
            end
            OPC_LDI: idx_reg = {4'h0, w.opcode[11:0]};
            OPC_JPV: begin nxt = w.opcode[11:0] + {4'd0, vreg[0]}; adv = 4'd0; end
            OPC_RND: begin r.reg_written = 1'b1; r.reg_value = w.random_byte & kk; end
            OPC_DRW: r.status = ST_NOT_HANDLED;
            OPC_KEY: begin
              if (kk == KK_SKP) begin if (keys_q[vx[3:0]]) adv = 4'd4; end
              else if (kk == KK_SKNP) begin if (!keys_q[vx[3:0]]) adv = 4'd4; end
              else r.status = ST_INVALID;
            end
            default: begin
              case (kk)
                KK_LDDT: begin r.reg_written = 1'b1; r.reg_value = delay_q; end
                KK_WAIT: begin waiting_q = 1'b1; target_q = x; end
                KK_SETDT: delay_q = vx;
                KK_SETST: sound_q = vx;
                KK_ADDI: idx_reg = idx_reg + {8'd0, vx};
                8'h29, 8'h30, 8'h33, 8'h55, 8'h65, 8'h75, 8'h85: r.status = ST_NOT_HANDLED;
                default: r.status = ST_INVALID;
              endcase
            end
          endcase
          if (r.reg_written) begin
            r.reg_index = x;
            vreg[x] = r.reg_value;
          end
          // Flag-setting ALU ops write VF after Vx, so the flag wins when x is F.
          if (hi == OPC_ALU) begin
            case (lo)
              ALU_ADD: vreg[15] = {7'd0, sum[8]};
              ALU_SUB: vreg[15] = {7'd0, vx >= vy};
              ALU_SHR: vreg[15] = {7'd0, vx[0]};
              ALU_SUBN: vreg[15] = {7'd0, vy >= vx};
              ALU_SHL: vreg[15] = {7'd0, vx[7]};
              default: ;
            endcase
          end
          pc_q = nxt + {8'd0, adv};
        end
      end
      MODE_KEY: begin
        keys_q[w.key_id] = w.key_pressed;
        if (waiting_q && w.key_pressed) begin
          r.reg_written = 1'b1;
          r.reg_index = target_q;
          r.reg_value = {4'd0, w.key_id};
          vreg[target_q] = r.reg_value;
          waiting_q = 1'b0;
        end
      end
      MODE_TICK: begin
        if (delay_q != 8'd0) delay_q--;
        if (sound_q != 8'd0) sound_q--;
      end
      default: r.status = ST_INVALID;
    endcase
    r.next_pc = pc_q;
    r.flag_value = vreg[15];
    r.index_value = idx_reg;
    r.waiting_key = waiting_q;
    r.sound_active = (sound_q != 8'd0);
    return r;
  endfunction

  // Drive one word; the prediction is made when the word is accepted.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_words.push_back(execute_word(w));
  endtask

  task automatic send_instr(logic [15:0] op);
    in_word_t w;
    w = '0;
    w.mode = MODE_INSTR;
    w.opcode = op;
    w.random_byte = 8'($urandom_range(255));
    send_word(w);
  endtask

  task automatic send_key(logic [3:0] k, logic down);
    in_word_t w;
    w = '0;
    w.mode = MODE_KEY;
    w.key_id = k;
    w.key_pressed = down;
    send_word(w);
  endtask

  task automatic send_tick();
    in_word_t w;
    w = '0;
    w.mode = MODE_TICK;
    send_word(w);
  endtask

  // Let the block drain fully so the configuration register can be written.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_program_start(logic [11:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_PROGRAM_START; pwdata <= {20'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pc_q = value;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[11:0] !== value) begin
      $display("%0t program_start readback expected %h actual %h", $time, value, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic test_reset_and_ops();
    // Return on empty stack, then every opcode family but 1nnn and 2nnn, with extreme operands.
    send_instr(OP_RET);
    send_instr(16'h6AFF); send_instr(16'h6B01); send_instr(16'h8AB4);
    send_instr(16'h6AFF); send_instr(16'h8BA5); send_instr(16'h8BA7);
    send_instr(16'h8AB1); send_instr(16'h8AB2); send_instr(16'h8AB3);
    send_instr(16'h8A06); send_instr(16'h6F81); send_instr(16'h8FFE);
    send_instr(16'h8F06); send_instr(16'h7AFF); send_instr(16'h8AB8);
    send_instr(16'h5AB1); send_instr(16'h5AB0); send_instr(16'h9AB0);
    send_instr(16'h9AB5); send_instr(16'h3AFE); send_instr(16'h4A00);
    send_instr(16'hAFFF); send_instr(16'hFF1E); send_instr(16'hFA1E);
    send_instr(16'hCAFF); send_instr(16'hC000); send_instr(16'hB123);
    send_instr(16'h0123); send_instr(16'hDFFF); send_instr(16'hF029);
    send_instr(16'hF0FF); send_instr(16'hE0FF); send_word('1);
  endtask

  task automatic test_keys_and_timers();
    send_instr(16'h6005);
    send_instr(16'hE09E); send_key(4'd5, 1'b1); send_instr(16'hE09E);
    send_instr(16'hE0A1); send_key(4'd5, 1'b0); send_instr(16'hE0A1);
    send_instr(16'h6102); send_instr(16'hF115); send_instr(16'hF118);
    send_tick(); send_instr(16'hF207); send_tick(); send_tick();
    // Key wait: instructions are blocked until a press, a release does not end it.
    send_instr(16'hF70A); send_instr(16'h6001); send_key(4'd15, 1'b0);
    send_key(4'd15, 1'b1); send_instr(16'hF707);
  endtask

  task automatic test_call_stack();
    write_program_start(12'd0);
    for (int i = 0; i < 17; i++) send_instr({OPC_CALL, 12'(i * 16 + 2)});
    for (int i = 0; i < 17; i++) send_instr(OP_RET);
  endtask

  task automatic test_end_of_memory();
    write_program_start(12'd4094);
    send_instr(16'h6301);
    send_instr(16'h6302);
    write_program_start(PC_LAST);
    send_instr(16'h6303);
    send_key(4'd0, 1'b1);
    send_tick();
    send_instr({OPC_JP, 12'hFFF});
    write_program_start(12'd4094);
    send_instr({OPC_JP, 12'hFFF});
    send_instr(16'h1200);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(3) != 0) begin
      case (op[15:12])
        OPC_SYS: if ($urandom_range(1) != 0) op = OP_RET;
        OPC_SE, OPC_SNE: if ($urandom_range(1) != 0) op[7:0] = vreg[op[11:8]];
        OPC_SEV, OPC_SNEV: op[3:0] = 4'h0;
        OPC_ALU: begin
          op[3:0] = 4'($urandom_range(8));
          if (op[3:0] == 4'h8) op[3:0] = ALU_SHL;
        end
        OPC_KEY: op[7:0] = ($urandom_range(1) != 0) ? KK_SKP : KK_SKNP;
        OPC_MISC: begin
          case ($urandom_range(5))
            0: op[7:0] = KK_LDDT;
            1: op[7:0] = KK_WAIT;
            2: op[7:0] = KK_SETDT;
            3: op[7:0] = KK_SETST;
            4: op[7:0] = KK_ADDI;
            default: op[7:0] = 8'h33;
          endcase
        end
        default: ;
      endcase
    end
    return op;
  endfunction

  task automatic test_random(int n, int gap, int stall);
    in_word_t w;
    int pick;
    gap_pct = gap;
    stall_pct = stall;
    write_program_start(12'($urandom_range(4094)));
    for (int i = 0; i < n; i++) begin
      // Recover from the last memory address now and then.
      if (i % 40 == 39) begin
        write_program_start(($urandom_range(1) != 0) ? 12'd0 : 12'($urandom_range(4094)));
      end
      pick = $urandom_range(99);
      w = '0;
      w.random_byte = 8'($urandom_range(255));
      if (pick < 18) begin
        w.mode = MODE_KEY;
        w.key_id = 4'($urandom_range(15));
        w.key_pressed = 1'($urandom_range(1));
        w.opcode = 16'($urandom_range(16'hFFFF));
      end else if (pick < 28) begin
        w.mode = MODE_TICK;
      end else if (pick < 30) begin
        w.opcode = 16'($urandom_range(16'hFFFF));
        w.key_id = 4'($urandom_range(15));
        w.key_pressed = 1'($urandom_range(1));
        w.mode = MODE_BAD;
      end else begin
        w.mode = MODE_INSTR;
        w.opcode = random_opcode();
      end
      send_word(w);
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $display("%0t %s expected %h actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  // Receiver: pop stalls at random while stall_pct is nonzero.
  always @(negedge clk) pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    out_word_t exp;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[chip8_instruction_execute] ERROR");
      $finish;
    end else if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, out_word);
        errors++;
      end else begin
        exp = expected_words.pop_front();
        check_field("next_pc", 16'(exp.next_pc), 16'(out_word.next_pc));
        check_field("status", 16'(exp.status), 16'(out_word.status));
        check_field("reg_written", 16'(exp.reg_written), 16'(out_word.reg_written));
        check_field("reg_index", 16'(exp.reg_index), 16'(out_word.reg_index));
        check_field("reg_value", 16'(exp.reg_value), 16'(out_word.reg_value));
        check_field("flag_value", 16'(exp.flag_value), 16'(out_word.flag_value));
        check_field("index_value", exp.index_value, out_word.index_value);
        check_field("waiting_key", 16'(exp.waiting_key), 16'(out_word.waiting_key));
        check_field("sound_active", 16'(exp.sound_active), 16'(out_word.sound_active));
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      vreg[i] = '0;
      call_stack[i] = '0;
    end
    idx_reg = '0; pc_q = ProgramStartReset; depth = 0;
    delay_q = '0; sound_q = '0; keys_q = '0; waiting_q = 1'b0; target_q = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_reset_and_ops();
    test_keys_and_timers();
    test_call_stack();
    test_end_of_memory();
    test_random(90, 0, 0);
    test_random(90, 51, 0);
    test_random(90, 0, 51);
    test_random(90, 16, 16);
    write_program_start(ProgramStartReset);
    if (errors == 0) begin
      $display("[chip8_instruction_execute] OK");
    end else begin
      $display("[chip8_instruction_execute] ERROR");
    end
    $finish;
  end
endmodule
